[design/tkm_pkg.sv]
// Shared constants, widths and the peak ordering function.
`default_nettype none
package tkm_pkg;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_PEAKS  = 16;
  localparam int SCORE_BITS = 16;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int FILL_W = $clog2(MAX_PEAKS + 1);

  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PK_CFG_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAKS_WANTED = 2'd2;

  localparam logic [CFG_W-1:0]    COLS_RESET  = 11'd640;
  localparam logic [CFG_W-1:0]    ROWS_RESET  = 11'd480;
  localparam logic [PK_CFG_W-1:0] PEAKS_RESET = 5'd10;

  typedef logic [SCORE_BITS-1:0] score_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;

  // a is weaker than b: lower score, then larger column, then larger row
  function automatic logic weaker(input score_t sa, input col_t ca, input row_t ra,
                                  input score_t sb, input col_t cb, input row_t rb);
    logic res;
    if (sa != sb) res = sa < sb;
    else if (ca != cb) res = ca > cb;
    else res = ra > rb;
    return res;
  endfunction
endpackage
`default_nettype wire

[design/tkm_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tkm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/top_k_local_maxima.sv]
// Top level: local-maximum detection over a score map and top-K peak table.
//
// Samples enter one at a time in raster order; each passes through acceptance
// with the read of the middle and upper line stores, a second read of the right
// neighbor from the one middle-line port, compare and write-back, then the
// counter advance. When the judged pixel is a maximum and the table has room it
// is inserted; when the table is full the weakest entry is first found by a scan
// of one entry per cycle and then possibly replaced. After the frame's last
// sample the final row is judged column by column (with the same table steps per
// offered maximum), then the peaks are sent weakest first, each after a scan of
// the table. No input is taken during that end-of-frame flush and emission.
`default_nettype none
module top_k_local_maxima (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tkm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tkm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [15:0]                   score,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [9:0]                         peak_col,
  output logic [9:0]                         peak_row,
  output logic [15:0]                        peak_score,
  output logic                               found,
  output logic                               last
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD2   = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_ADV   = 4'd3;
  localparam logic [3:0] S_OSCAN = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FRD2  = 4'd6;
  localparam logic [3:0] S_FEV   = 4'd7;
  localparam logic [3:0] S_FADV  = 4'd8;
  localparam logic [3:0] S_ESCAN = 4'd9;
  localparam logic [3:0] S_EOUT  = 4'd10;

  localparam int CW = tkm_pkg::CFG_W;
  localparam int FW = tkm_pkg::FILL_W;
  localparam int NP = tkm_pkg::MAX_PEAKS;

  logic [3:0] st;
  logic [CW-1:0] frame_cols, frame_rows;
  logic [tkm_pkg::PK_CFG_W-1:0] peaks_wanted;

  tkm_pkg::col_t column_count, c_reg;
  tkm_pkg::row_t row_count, r_reg;
  tkm_pkg::score_t s_reg, v_reg, u_reg, left_reg;
  logic in_flush;

  tkm_pkg::score_t tab_s [NP];
  tkm_pkg::col_t   tab_c [NP];
  tkm_pkg::row_t   tab_r [NP];
  logic [NP-1:0]   used;
  logic [FW-1:0]   fill, scan_i, emit_k;
  logic [tkm_pkg::IDX_W-1:0] w_idx;
  logic w_any;
  tkm_pkg::score_t w_s, cand_s;
  tkm_pkg::col_t   w_c, cand_c;
  tkm_pkg::row_t   w_r, cand_r;

  // clamped geometry
  logic [CW-1:0] cols, rows;
  logic [FW-1:0] k_cap;
  tkm_pkg::col_t c_eff;
  tkm_pkg::row_t r_eff;
  logic hr_reg, last_row;

  always_comb begin
    if (frame_cols == '0) cols = CW'(1);
    else if (frame_cols > CW'(tkm_pkg::MAX_COLS)) cols = CW'(tkm_pkg::MAX_COLS);
    else cols = frame_cols;
    if (frame_rows == '0) rows = CW'(1);
    else if (frame_rows > CW'(tkm_pkg::MAX_ROWS)) rows = CW'(tkm_pkg::MAX_ROWS);
    else rows = frame_rows;
    if (peaks_wanted == '0) k_cap = FW'(1);
    else if (FW'(peaks_wanted) > FW'(NP)) k_cap = FW'(NP);
    else k_cap = FW'(peaks_wanted);
    c_eff = ({1'b0, column_count} >= cols) ? tkm_pkg::col_t'(cols - CW'(1)) : column_count;
    r_eff = ({1'b0, row_count} >= rows) ? tkm_pkg::row_t'(rows - CW'(1)) : row_count;
    hr_reg   = ({1'b0, c_reg} + CW'(1)) < cols;
    last_row = !(({1'b0, r_reg} + CW'(1)) < rows);
  end

  // line stores
  logic mid_we, up_we;
  tkm_pkg::col_t mid_waddr, mid_raddr, up_raddr;
  tkm_pkg::score_t mid_wdata, mid_q, up_q;

  always_comb begin
    mid_we    = (st == S_EVAL);
    mid_waddr = c_reg;
    mid_wdata = s_reg;
    up_we     = (st == S_EVAL) && (r_reg != '0);
    case (st)
      S_IDLE:         mid_raddr = c_eff;
      S_RD2, S_FRD2:  mid_raddr = c_reg + tkm_pkg::col_t'(1);
      default:        mid_raddr = c_reg;
    endcase
    up_raddr = (st == S_IDLE) ? c_eff : c_reg;
  end

  tkm_ram #(.WIDTH(tkm_pkg::SCORE_BITS), .DEPTH(tkm_pkg::MAX_COLS)) u_mid (
    .clk(clk), .we(mid_we), .waddr(mid_waddr), .wdata(mid_wdata),
    .raddr(mid_raddr), .rdata(mid_q)
  );
  tkm_ram #(.WIDTH(tkm_pkg::SCORE_BITS), .DEPTH(tkm_pkg::MAX_COLS)) u_up (
    .clk(clk), .we(up_we), .waddr(c_reg), .wdata(v_reg),
    .raddr(up_raddr), .rdata(up_q)
  );

  // peak tests
  logic peak_str, peak_fl;
  always_comb begin
    peak_str = (r_reg != '0) && (c_reg == '0 || v_reg >= left_reg) &&
               (!hr_reg || v_reg >= mid_q) &&
               (r_reg < tkm_pkg::row_t'(2) || v_reg > u_reg) && (v_reg > s_reg);
    peak_fl  = (c_reg == '0 || v_reg >= left_reg) && (!hr_reg || v_reg >= mid_q) &&
               (r_reg == '0 || v_reg > u_reg);
  end

  // table scan read
  tkm_pkg::score_t sc_s;
  tkm_pkg::col_t   sc_c;
  tkm_pkg::row_t   sc_r;
  logic sc_weaker;
  always_comb begin
    sc_s = tab_s[scan_i[tkm_pkg::IDX_W-1:0]];
    sc_c = tab_c[scan_i[tkm_pkg::IDX_W-1:0]];
    sc_r = tab_r[scan_i[tkm_pkg::IDX_W-1:0]];
    sc_weaker = !w_any || tkm_pkg::weaker(sc_s, sc_c, sc_r, w_s, w_c, w_r);
  end

  assign in_ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      frame_cols <= tkm_pkg::COLS_RESET;
      frame_rows <= tkm_pkg::ROWS_RESET;
      peaks_wanted <= tkm_pkg::PEAKS_RESET;
      column_count <= '0;
      row_count <= '0;
      fill <= '0;
      in_flush <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tkm_pkg::REG_FRAME_COLS:   frame_cols <= cfg_data;
          tkm_pkg::REG_FRAME_ROWS:   frame_rows <= cfg_data;
          tkm_pkg::REG_PEAKS_WANTED: peaks_wanted <= cfg_data[tkm_pkg::PK_CFG_W-1:0];
          default: ;
        endcase
      end
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            s_reg <= score;
            c_reg <= c_eff;
            r_reg <= r_eff;
            st <= S_RD2;
          end
        end
        S_RD2: begin
          v_reg <= mid_q;
          u_reg <= up_q;
          st <= S_EVAL;
        end
        S_EVAL: begin
          if (r_reg != '0) left_reg <= v_reg;
          cand_s <= v_reg;
          cand_c <= c_reg;
          cand_r <= r_reg - tkm_pkg::row_t'(1);
          scan_i <= '0;
          w_any <= 1'b0;
          st <= peak_str ? S_OSCAN : S_ADV;
        end
        S_ADV: begin
          if (hr_reg) begin
            column_count <= c_reg + tkm_pkg::col_t'(1);
            row_count <= r_reg;
            st <= S_IDLE;
          end else begin
            column_count <= '0;
            if (!last_row) begin
              row_count <= r_reg + tkm_pkg::row_t'(1);
              st <= S_IDLE;
            end else begin
              // judge the final row before emission
              row_count <= '0;
              in_flush <= 1'b1;
              c_reg <= '0;
              st <= S_FRD;
            end
          end
        end
        S_OSCAN: begin
          if (fill < k_cap) begin
            tab_s[fill[tkm_pkg::IDX_W-1:0]] <= cand_s;
            tab_c[fill[tkm_pkg::IDX_W-1:0]] <= cand_c;
            tab_r[fill[tkm_pkg::IDX_W-1:0]] <= cand_r;
            fill <= fill + FW'(1);
            st <= in_flush ? S_FADV : S_ADV;
          end else if (scan_i < fill) begin
            if (sc_weaker) begin
              w_idx <= scan_i[tkm_pkg::IDX_W-1:0];
              w_s <= sc_s;
              w_c <= sc_c;
              w_r <= sc_r;
              w_any <= 1'b1;
            end
            scan_i <= scan_i + FW'(1);
          end else begin
            if (cand_s > w_s) begin
              tab_s[w_idx] <= cand_s;
              tab_c[w_idx] <= cand_c;
              tab_r[w_idx] <= cand_r;
            end
            st <= in_flush ? S_FADV : S_ADV;
          end
        end
        S_FRD: st <= S_FRD2;
        S_FRD2: begin
          v_reg <= mid_q;
          u_reg <= up_q;
          st <= S_FEV;
        end
        S_FEV: begin
          left_reg <= v_reg;
          cand_s <= v_reg;
          cand_c <= c_reg;
          cand_r <= r_reg;
          scan_i <= '0;
          w_any <= 1'b0;
          st <= peak_fl ? S_OSCAN : S_FADV;
        end
        S_FADV: begin
          scan_i <= '0;
          w_any <= 1'b0;
          used <= '0;
          emit_k <= '0;
          if (hr_reg) begin
            c_reg <= c_reg + tkm_pkg::col_t'(1);
            st <= S_FRD;
          end else if (fill == '0) begin
            peak_col <= '0;
            peak_row <= '0;
            peak_score <= '0;
            found <= 1'b0;
            last <= 1'b1;
            out_valid <= 1'b1;
            st <= S_EOUT;
          end else begin
            st <= S_ESCAN;
          end
        end
        S_ESCAN: begin
          if (scan_i < fill) begin
            if (!used[scan_i[tkm_pkg::IDX_W-1:0]] && sc_weaker) begin
              w_idx <= scan_i[tkm_pkg::IDX_W-1:0];
              w_s <= sc_s;
              w_c <= sc_c;
              w_r <= sc_r;
              w_any <= 1'b1;
            end
            scan_i <= scan_i + FW'(1);
          end else begin
            used[w_idx] <= 1'b1;
            peak_col <= w_c;
            peak_row <= w_r;
            peak_score <= w_s;
            found <= 1'b1;
            last <= (emit_k + FW'(1)) == fill;
            out_valid <= 1'b1;
            st <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            scan_i <= '0;
            w_any <= 1'b0;
            if (last) begin
              fill <= '0;
              in_flush <= 1'b0;
              st <= S_IDLE;
            end else begin
              emit_k <= emit_k + FW'(1);
              st <= S_ESCAN;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/tkm_checker.sv]
// Port-level checks for the top-K local maxima block, bound to the top level.
`default_nettype none
module tkm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [9:0]  peak_col,
  input wire logic [9:0]  peak_row,
  input wire logic [15:0] peak_score,
  input wire logic        found,
  input wire logic        last
);
  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(peak_col) && $stable(peak_row)
      && $stable(peak_score) && $stable(found) && $stable(last))
    else $error("result changed while stalled");

  a_no_input_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken during emission");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last)
    else $error("empty frame result not last");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("block did not rearm after last result");
endmodule

bind top_k_local_maxima tkm_checker u_tkm_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .peak_col(peak_col), .peak_row(peak_row),
  .peak_score(peak_score), .found(found), .last(last)
);
`default_nettype wire
